/* design/positional_list_engine_top_defines.svh */
// Assertion helpers for the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PLE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/plist_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_pkg
// Shared constants, command and status codes, and the store port bundle.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int CMD_W    = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 3;
    localparam int CMP_W    = ((POS_W > CW) ? POS_W : CW) + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_PREPEND   = 3'd1,
        CMD_INSERT_AT = 3'd2,
        CMD_DUMP      = 3'd3,
        CMD_UPDATE_AT = 3'd4,
        CMD_DEL_FIRST = 3'd5,
        CMD_DEL_LAST  = 3'd6,
        CMD_DEL_AT    = 3'd7
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_BAD_POS = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_BAD_CMD = 3'd4
    } t_status;

    typedef struct packed {
        logic             we;
        logic [AW-1:0]    waddr;
        logic [VAL_W-1:0] wdata;
        logic             re;
        logic [AW-1:0]    raddr;
    } t_ram_req;

endpackage
`default_nettype wire

/* design/plist_cmd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_cmd_if
// Command channel: valid/ready handshake with command, position and value.
// ----------------------------------------------------------------------------
interface plist_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [plist_pkg::CMD_W-1:0]         command;
    logic [plist_pkg::POS_W-1:0]         position;
    logic signed [plist_pkg::VAL_W-1:0]  value;

    modport source (output valid, output command, output position, output value,
                    input ready);
    modport sink   (input valid, input command, input position, input value,
                    output ready);
endinterface
`default_nettype wire

/* design/plist_res_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_res_if
// Result channel: valid/ready handshake with status, element and last flag.
// ----------------------------------------------------------------------------
interface plist_res_if;
    logic                                valid;
    logic                                ready;
    logic [plist_pkg::STAT_W-1:0]        status;
    logic signed [plist_pkg::VAL_W-1:0]  element;
    logic                                last;

    modport source (output valid, output status, output element, output last,
                    input ready);
    modport sink   (input valid, input status, input element, input last,
                    output ready);
endinterface
`default_nettype wire

/* design/positional_list_engine_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// A request without data movement passes through S_RESP into the registered result slot.
// Insert or delete at position p moves the entries behind p through the store, one per
// cycle, bounded by the single store write port. A dump emits one element per cycle while
// the result slot is free, after a registered store read, CAPACITY elements at most.
// One request is worked at a time; the next is taken once the result is queued.
// Reset clears the length count and control state; store contents are not cleared.
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Ordered list of signed values held in a synchronous store plus a length count.
// ----------------------------------------------------------------------------
`include "positional_list_engine_top_defines.svh"

module positional_list_engine_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    plist_cmd_if.sink    i_cmd,
    plist_res_if.source  o_res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOVE = 5'b00010,
        S_PUT  = 5'b00100,
        S_RESP = 5'b01000,
        S_DUMP = 5'b10000
    } t_state;

    t_state                         r_state, n_state;
    logic [plist_pkg::CW-1:0]       r_count, n_count;
    logic [plist_pkg::AW-1:0]       r_ptr, n_ptr;
    logic [plist_pkg::AW-1:0]       r_stop, n_stop;
    logic [plist_pkg::AW-1:0]       r_put_addr, n_put_addr;
    logic                           r_up, n_up;
    logic [plist_pkg::VAL_W-1:0]    r_val, n_val;
    plist_pkg::t_status             r_status, n_status;
    logic                           r_out_valid, n_out_valid;
    plist_pkg::t_status             r_out_status, n_out_status;
    logic [plist_pkg::VAL_W-1:0]    r_out_elem, n_out_elem;
    logic                           r_out_last, n_out_last;

    plist_pkg::t_ram_req            ram_req;
    logic [plist_pkg::VAL_W-1:0]    ram_rdata;

    logic                           w_acc;
    logic                           w_slot_free;

    plist_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign i_cmd.ready   = (r_state == S_IDLE);
    assign w_acc         = i_cmd.valid && (r_state == S_IDLE);
    assign w_slot_free   = !r_out_valid || o_res.ready;

    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_out_status;
    assign o_res.element = r_out_elem;
    assign o_res.last    = r_out_last;

    always_comb begin
        logic [plist_pkg::CMP_W-1:0] cx;
        logic [plist_pkg::CMP_W-1:0] px;
        logic [plist_pkg::POS_W-1:0] pos_m1;
        logic [plist_pkg::AW-1:0]    pos_idx;
        logic [plist_pkg::AW-1:0]    cnt_idx;
        logic [plist_pkg::AW-1:0]    last_idx;
        logic [plist_pkg::AW-1:0]    idx;
        logic                        full;
        logic                        empty;
        logic                        pos_zero;
        logic                        pos_gt_c;
        logic                        pos_gt_c1;
        logic                        do_ins;
        logic                        do_del;
        logic                        dump_last;

        cx        = plist_pkg::CMP_W'(r_count);
        px        = plist_pkg::CMP_W'(i_cmd.position);
        pos_m1    = i_cmd.position - plist_pkg::POS_W'(1);
        pos_idx   = plist_pkg::AW'(pos_m1);
        cnt_idx   = r_count[plist_pkg::AW-1:0];
        last_idx  = cnt_idx - plist_pkg::AW'(1);
        full      = (r_count == plist_pkg::CW'(plist_pkg::CAPACITY));
        empty     = (r_count == '0);
        pos_zero  = (i_cmd.position == '0);
        pos_gt_c  = (px > cx);
        pos_gt_c1 = (px > (cx + plist_pkg::CMP_W'(1)));
        do_ins    = 1'b0;
        do_del    = 1'b0;
        idx       = '0;
        dump_last = (r_ptr == r_stop);

        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_stop       = r_stop;
        n_put_addr   = r_put_addr;
        n_up         = r_up;
        n_val        = r_val;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_elem   = r_out_elem;
        n_out_last   = r_out_last;
        ram_req      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_status = plist_pkg::ST_OK;
                    n_state  = S_RESP;
                    n_val    = i_cmd.value;
                    unique case (plist_pkg::t_cmd'(i_cmd.command))
                        plist_pkg::CMD_APPEND: begin
                            if (full) begin
                                n_status = plist_pkg::ST_FULL;
                            end else begin
                                do_ins = 1'b1;
                                idx    = cnt_idx;
                            end
                        end
                        plist_pkg::CMD_PREPEND: begin
                            if (full) begin
                                n_status = plist_pkg::ST_FULL;
                            end else begin
                                do_ins = 1'b1;
                                idx    = '0;
                            end
                        end
                        plist_pkg::CMD_INSERT_AT: begin
                            if (pos_zero || pos_gt_c1) begin
                                n_status = plist_pkg::ST_BAD_POS;
                            end else if (full) begin
                                n_status = plist_pkg::ST_FULL;
                            end else begin
                                do_ins = 1'b1;
                                idx    = pos_idx;
                            end
                        end
                        plist_pkg::CMD_DUMP: begin
                            if (empty) begin
                                n_status = plist_pkg::ST_EMPTY;
                            end else begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = '0;
                                n_ptr         = '0;
                                n_stop        = last_idx;
                                n_state       = S_DUMP;
                            end
                        end
                        plist_pkg::CMD_UPDATE_AT: begin
                            if (pos_zero) begin
                                n_status = plist_pkg::ST_BAD_POS;
                            end else if (empty) begin
                                n_status = plist_pkg::ST_EMPTY;
                            end else if (pos_gt_c) begin
                                n_status = plist_pkg::ST_BAD_POS;
                            end else begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = pos_idx;
                                ram_req.wdata = i_cmd.value;
                            end
                        end
                        plist_pkg::CMD_DEL_FIRST: begin
                            if (empty) begin
                                n_status = plist_pkg::ST_EMPTY;
                            end else begin
                                do_del = 1'b1;
                                idx    = '0;
                            end
                        end
                        plist_pkg::CMD_DEL_LAST: begin
                            if (empty) begin
                                n_status = plist_pkg::ST_EMPTY;
                            end else begin
                                do_del = 1'b1;
                                idx    = last_idx;
                            end
                        end
                        plist_pkg::CMD_DEL_AT: begin
                            if (empty) begin
                                n_status = plist_pkg::ST_EMPTY;
                            end else if (pos_zero || pos_gt_c) begin
                                n_status = plist_pkg::ST_BAD_POS;
                            end else begin
                                do_del = 1'b1;
                                idx    = pos_idx;
                            end
                        end
                    endcase

                    if (do_ins) begin
                        n_count = r_count + plist_pkg::CW'(1);
                        if (idx == cnt_idx) begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = idx;
                            ram_req.wdata = i_cmd.value;
                        end else begin
                            // shift the tail up, starting from the last entry
                            ram_req.re    = 1'b1;
                            ram_req.raddr = last_idx;
                            n_ptr         = last_idx;
                            n_stop        = idx;
                            n_put_addr    = idx;
                            n_up          = 1'b0;
                            n_state       = S_MOVE;
                        end
                    end
                    if (do_del) begin
                        n_count = r_count - plist_pkg::CW'(1);
                        if (idx != last_idx) begin
                            // pull the tail down, starting just past the hole
                            ram_req.re    = 1'b1;
                            ram_req.raddr = idx + plist_pkg::AW'(1);
                            n_ptr         = idx + plist_pkg::AW'(1);
                            n_stop        = last_idx;
                            n_up          = 1'b1;
                            n_state       = S_MOVE;
                        end
                    end
                end
            end
            S_MOVE: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_up ? (r_ptr - plist_pkg::AW'(1))
                                     : (r_ptr + plist_pkg::AW'(1));
                ram_req.wdata = ram_rdata;
                if (r_ptr == r_stop) begin
                    n_state = r_up ? S_RESP : S_PUT;
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = r_up ? (r_ptr + plist_pkg::AW'(1))
                                         : (r_ptr - plist_pkg::AW'(1));
                    n_ptr         = ram_req.raddr;
                end
            end
            S_PUT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_put_addr;
                ram_req.wdata = r_val;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_elem   = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DUMP: begin
                // read data holds while the output slot is busy
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = plist_pkg::ST_OK;
                    n_out_elem   = ram_rdata;
                    n_out_last   = dump_last;
                    if (dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = r_ptr + plist_pkg::AW'(1);
                        n_ptr         = r_ptr + plist_pkg::AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_stop       <= n_stop;
        r_put_addr   <= n_put_addr;
        r_up         <= n_up;
        r_val        <= n_val;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_elem   <= n_out_elem;
        r_out_last   <= n_out_last;
    end

    `PLE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= plist_pkg::CW'(plist_pkg::CAPACITY), "length count beyond capacity")
    `PLE_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, ram_req.we && ram_req.re, ram_req.waddr != ram_req.raddr, "store read and write hit one entry")
    `PLE_ASSERT_NXT(a_err_keeps_len, i_clk, i_rst_n, w_acc && (n_status != plist_pkg::ST_OK), r_count == $past(r_count), "failed request changed the length")
    `PLE_ASSERT_IMP(a_mid_dump_ok, i_clk, i_rst_n, o_res.valid && !o_res.last, o_res.status == plist_pkg::ST_OK, "non-final result without ok status")

endmodule
`default_nettype wire

/* design/plist_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plist_ram
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module plist_ram (
    input  wire logic                          i_clk,
    input  wire plist_pkg::t_ram_req           i_req,
    output logic [plist_pkg::VAL_W-1:0]        o_rdata
);

    logic [plist_pkg::VAL_W-1:0] r_mem [plist_pkg::CAPACITY];
    logic [plist_pkg::VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        // hold read data until the next read
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire
